FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Operation and error codes, fixed port field widths and the control bundle
// that the top level broadcasts to every cell of the row.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Widths of the item fields on the ports; these do not follow the
   // internal value width.
   localparam int FIELD_WIDTH = 32;
   localparam int COUNT_FIELD_WIDTH = 5;
   localparam int ERROR_FIELD_WIDTH = 2;

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } spq_func_type;

   typedef enum logic [ERROR_FIELD_WIDTH-1:0] {
      ERR_NONE       = 2'd0,
      ERR_POP_EMPTY  = 2'd1,
      ERR_PUSH_FULL  = 2'd2
   } spq_error_type;

   typedef struct packed {
      logic push_en;
      logic pop_en;
   } spq_ctl_type;

endpackage

FILE: rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: minimum priority queue with sorted insertion
// A row of CAPACITY cells keeps the values in ascending order. A push is
// broadcast to every cell, which compares it with its own value and shifts
// right where needed; a pop shifts the whole row left. The compare and shift
// across the cell row is combinational and its result is registered, so one
// item is accepted per clock cycle while rsp_ready is high or no result waits,
// and its result appears in the cycle after acceptance. No clearing pass is
// needed after reset, the fill count alone marks which cells hold values.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_func,
   input  logic [spq_pkg::FIELD_WIDTH-1:0]         req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [spq_pkg::FIELD_WIDTH-1:0]         rsp_front_value,
   output logic                                    rsp_is_empty,
   output logic                                    rsp_is_full,
   output logic [spq_pkg::COUNT_FIELD_WIDTH-1:0]   rsp_fill_count,
   output logic [spq_pkg::ERROR_FIELD_WIDTH-1:0]  rsp_error_code
);

   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int FW = spq_pkg::FIELD_WIDTH;
   localparam int CFW = spq_pkg::COUNT_FIELD_WIDTH;

   logic                          req_accept;
   logic                          is_push;
   logic                          full;
   logic                          empty;
   spq_pkg::spq_ctl_type          ctl;
   logic [VALUE_WIDTH-1:0]        new_value;

   logic [COUNT_WIDTH-1:0]        count_ff;
   logic [COUNT_WIDTH-1:0]        count_in;

   logic [CAPACITY-1:0]           keep_chain;
   logic [CAPACITY-1:0]           occupied;
   logic [VALUE_WIDTH-1:0]        values [CAPACITY];
   logic [VALUE_WIDTH-1:0]        next_values [CAPACITY];
   logic [VALUE_WIDTH-1:0]        front_in;

   logic                          rsp_valid_ff;
   logic [FW-1:0]                 front_ff;
   logic [FW-1:0]                 front_field;
   logic                          empty_ff;
   logic                          full_ff;
   logic [CFW-1:0]                count_out_ff;
   logic [CFW-1:0]                count_field;
   spq_pkg::spq_error_type        error_ff;
   spq_pkg::spq_error_type        error_in;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign is_push    = (req_func == spq_pkg::FUNC_PUSH);
   assign full       = (count_ff == COUNT_WIDTH'(CAPACITY));
   assign empty      = (count_ff == '0);

   // The 32-bit field is sign-extended or truncated to the stored width.
   generate
      if (VALUE_WIDTH > FW) begin : g_value_ext
         assign new_value = {{(VALUE_WIDTH - FW){req_value[FW-1]}}, req_value};
      end else begin : g_value_trunc
         assign new_value = req_value[VALUE_WIDTH-1:0];
      end
   endgenerate

   always_comb begin
      ctl.push_en = req_accept && is_push && !full;
      ctl.pop_en  = req_accept && !is_push && !empty;
      count_in    = count_ff;
      error_in    = spq_pkg::ERR_NONE;
      if (ctl.push_en) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (ctl.pop_en) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
      if (req_accept && is_push && full) begin
         error_in = spq_pkg::ERR_PUSH_FULL;
      end else if (req_accept && !is_push && empty) begin
         error_in = spq_pkg::ERR_POP_EMPTY;
      end
   end

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic                   left_keep;
         logic [VALUE_WIDTH-1:0] left_value;
         logic [VALUE_WIDTH-1:0] right_value;

         assign occupied[i] = (count_ff > COUNT_WIDTH'(i));

         if (i == 0) begin : g_head
            assign left_keep  = 1'b1;
            assign left_value = new_value;
         end else begin : g_body
            assign left_keep  = keep_chain[i-1];
            assign left_value = values[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign right_value = values[i];
         end else begin : g_inner
            assign right_value = values[i+1];
         end

         spq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .new_value   (new_value),
            .occupied    (occupied[i]),
            .left_keep   (left_keep),
            .left_value  (left_value),
            .right_value (right_value),
            .keep        (keep_chain[i]),
            .value       (values[i]),
            .value_next  (next_values[i])
         );
      end
   endgenerate

   assign front_in = (count_in == '0) ? '0 : next_values[0];

   // The front field carries the low bits of the stored value, zero-filled
   // when the stored width is narrower than the port.
   generate
      if (VALUE_WIDTH >= FW) begin : g_front_trunc
         assign front_field = front_in[FW-1:0];
      end else begin : g_front_ext
         assign front_field = {{(FW - VALUE_WIDTH){1'b0}}, front_in};
      end
      if (COUNT_WIDTH >= CFW) begin : g_count_trunc
         assign count_field = count_in[CFW-1:0];
      end else begin : g_count_ext
         assign count_field = {{(CFW - COUNT_WIDTH){1'b0}}, count_in};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         front_ff     <= front_field;
         empty_ff     <= (count_in == '0);
         full_ff      <= (count_in == COUNT_WIDTH'(CAPACITY));
         count_out_ff <= count_field;
         error_ff     <= error_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = front_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;
   assign rsp_fill_count  = count_out_ff;
   assign rsp_error_code  = error_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(CAPACITY))
      else $error("fill count exceeds capacity");

   a_push_full_dropped : assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_push && full) |=>
         (count_ff == $past(count_ff)) && (rsp_error_code == spq_pkg::ERR_PUSH_FULL))
      else $error("push on full queue was not dropped");

   a_pop_decrements : assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_push && !empty) |=>
         (count_ff == $past(count_ff) - COUNT_WIDTH'(1)))
      else $error("pop did not remove one item");

   a_empty_front_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_front_value == '0) && !rsp_is_full)
      else $error("empty result shows a front value");

endmodule

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one value, compares it against the broadcast push value and either
// keeps it, takes the new value, takes its left neighbor's value or takes its
// right neighbor's value.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  spq_pkg::spq_ctl_type    ctl,
   input  logic [VALUE_WIDTH-1:0]  new_value,
   input  logic                    occupied,
   input  logic                    left_keep,
   input  logic [VALUE_WIDTH-1:0]  left_value,
   input  logic [VALUE_WIDTH-1:0]  right_value,
   output logic                    keep,
   output logic [VALUE_WIDTH-1:0]  value,
   output logic [VALUE_WIDTH-1:0]  value_next
);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   // A stored value that is less than or equal to the new one stays ahead of
   // it, which keeps equal values in arrival order.
   assign keep = occupied && ($signed(value_ff) <= $signed(new_value));

   always_comb begin
      value_in = value_ff;
      if (ctl.push_en) begin
         if (keep) begin
            value_in = value_ff;
         end else if (left_keep) begin
            value_in = new_value;
         end else begin
            value_in = left_value;
         end
      end else if (ctl.pop_en) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign value_next = value_in;

endmodule
